/* rtl/bqc_pkg.sv */
// ----------------------------------------------------------------------------
// bqc_pkg
// Shared constants, types and the control store of the biquad cascade.
// ----------------------------------------------------------------------------
package bqc_pkg;

  // filter geometry
  localparam int SECTIONS    = 3;
  localparam int CHANNELS    = 2;
  localparam int SAMPLE_BITS = 24;

  // coefficients are Q3.21 for 24-bit samples
  localparam int COEF_FRAC = SAMPLE_BITS - 3;
  localparam int NCOEF     = SECTIONS * 5;
  localparam int NROW      = CHANNELS * SECTIONS;

  localparam int SEC_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int ROW_W  = (NROW > 1) ? $clog2(NROW) : 1;
  localparam int CIDX_W = $clog2(NCOEF);

  // product and five-term accumulator widths
  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + 3;

  localparam int STEP_W = 3;

  typedef enum logic [1:0] {
    OP_FILTER = 2'd0,
    OP_WRITE  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  // multiplier operand, same order as the coefficient positions
  typedef enum logic [2:0] {
    TAP_X  = 3'd0,
    TAP_X1 = 3'd1,
    TAP_X2 = 3'd2,
    TAP_Y1 = 3'd3,
    TAP_Y2 = 3'd4
  } tap_e;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2,
    ACC_SUB  = 2'd3
  } acc_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_e;

  // one control word per step
  typedef struct packed {
    logic mul_en;
    tap_e tap;
    acc_e acc;
    logic finish;
  } uword_t;

  // control store: one section per pass, the product lags the multiply by a step
  function automatic uword_t ucode(logic [STEP_W-1:0] step);
    uword_t w;
    w = '{mul_en: 1'b0, tap: TAP_X, acc: ACC_HOLD, finish: 1'b0};
    unique case (step)
      3'd0:    w = '{mul_en: 1'b1, tap: TAP_X,  acc: ACC_HOLD, finish: 1'b0};
      3'd1:    w = '{mul_en: 1'b1, tap: TAP_X1, acc: ACC_LOAD, finish: 1'b0};
      3'd2:    w = '{mul_en: 1'b1, tap: TAP_X2, acc: ACC_ADD,  finish: 1'b0};
      3'd3:    w = '{mul_en: 1'b1, tap: TAP_Y1, acc: ACC_ADD,  finish: 1'b0};
      3'd4:    w = '{mul_en: 1'b1, tap: TAP_Y2, acc: ACC_SUB,  finish: 1'b0};
      3'd5:    w = '{mul_en: 1'b0, tap: TAP_X,  acc: ACC_SUB,  finish: 1'b0};
      3'd6:    w = '{mul_en: 1'b0, tap: TAP_X,  acc: ACC_HOLD, finish: 1'b1};
      default: w = '{mul_en: 1'b0, tap: TAP_X,  acc: ACC_HOLD, finish: 1'b0};
    endcase
    return w;
  endfunction

endpackage

/* rtl/biquad_cascade_filter_unit.sv */
// Schedule: a filter request runs seven control steps per section, three sections,
//   on one shared multiplier; the last section holds while a held result is not taken.
// Requests: a new request is taken only while the sequencer is idle, so a filter request
//   finishes before the next is accepted; write and clear requests give no result.
// Reset: coefficients return to pass-through (every b0 one), history is zeroed,
//   the sequencer goes idle and the output register empties.
// ----------------------------------------------------------------------------
// biquad_cascade_filter_unit
// Direct-form-I biquad cascade with per-channel history, driven by a small
// microcoded sequencer around one multiply-accumulate datapath.
// ----------------------------------------------------------------------------
module biquad_cascade_filter_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [1:0]                             operation_i,
  input  logic                                   channel_i,
  input  logic signed [bqc_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  logic [3:0]                             coefficient_index_i,
  input  logic signed [bqc_pkg::SAMPLE_BITS-1:0] coefficient_value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [bqc_pkg::SAMPLE_BITS-1:0] sample_out_o,
  output logic                                   channel_out_o,
  output logic                                   clipped_o
);
  import bqc_pkg::*;

  localparam logic signed [ACC_W-1:0] MAXV = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] MINV = -MAXV - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (COEF_FRAC - 1);
  localparam logic [SEC_W-1:0]        SEC_LAST = SEC_W'(SECTIONS - 1);

  state_e                         state_q, state_d;
  logic [STEP_W-1:0]              step_q, step_d;
  logic [SEC_W-1:0]               sec_q, sec_d;
  logic                           ch_q;
  logic signed [SAMPLE_BITS-1:0]  x_q;
  logic                           clip_q;
  logic signed [PROD_W-1:0]       prod_q;
  logic signed [ACC_W-1:0]        acc_q;
  logic                           out_valid_q;
  logic signed [SAMPLE_BITS-1:0]  out_sample_q;
  logic                           out_ch_q;
  logic                           out_clip_q;

  logic signed [SAMPLE_BITS-1:0]  coef_q [NCOEF];
  logic signed [SAMPLE_BITS-1:0]  hx1_q [NROW];
  logic signed [SAMPLE_BITS-1:0]  hx2_q [NROW];
  logic signed [SAMPLE_BITS-1:0]  hy1_q [NROW];
  logic signed [SAMPLE_BITS-1:0]  hy2_q [NROW];

  uword_t                         uw;
  logic                           accept;
  logic                           filter_req;
  logic                           last_sec;
  logic                           can_emit;
  logic                           advance;
  logic [ROW_W-1:0]               row;
  logic [CIDX_W-1:0]              cidx;
  logic signed [SAMPLE_BITS-1:0]  opnd;
  logic signed [ACC_W-1:0]        prod_ext;
  logic signed [ACC_W-1:0]        rnd;
  logic signed [ACC_W-1:0]        quo;
  logic signed [SAMPLE_BITS-1:0]  y_sat;
  logic                           sat;

  // handshake and control decode
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign filter_req = accept && (op_e'(operation_i) == OP_FILTER)
                      && (int'(channel_i) < CHANNELS);
  assign uw         = ucode(step_q);
  assign last_sec   = (sec_q == SEC_LAST);
  assign can_emit   = !out_valid_q || out_ready_i;
  assign advance    = uw.finish && (!last_sec || can_emit);

  // history row and coefficient address
  assign row  = ROW_W'(int'(ch_q) * SECTIONS + int'(sec_q));
  assign cidx = CIDX_W'(int'(sec_q) * 5 + int'(uw.tap));

  // multiplier operand select
  always_comb begin
    unique case (uw.tap)
      TAP_X:   opnd = x_q;
      TAP_X1:  opnd = hx1_q[row];
      TAP_X2:  opnd = hx2_q[row];
      TAP_Y1:  opnd = hy1_q[row];
      TAP_Y2:  opnd = hy2_q[row];
      default: opnd = x_q;
    endcase
  end

  // round half up, then saturate to the sample range
  assign prod_ext = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign rnd      = acc_q + HALF;
  assign quo      = rnd >>> COEF_FRAC;
  always_comb begin
    sat   = 1'b0;
    y_sat = quo[SAMPLE_BITS-1:0];
    if (quo > MAXV) begin
      sat   = 1'b1;
      y_sat = MAXV[SAMPLE_BITS-1:0];
    end else if (quo < MINV) begin
      sat   = 1'b1;
      y_sat = MINV[SAMPLE_BITS-1:0];
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    sec_d   = sec_q;
    unique case (state_q)
      ST_IDLE: begin
        step_d = '0;
        sec_d  = '0;
        if (filter_req) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (uw.finish) begin
          if (advance) begin
            step_d = '0;
            if (last_sec) begin
              state_d = ST_IDLE;
              sec_d   = '0;
            end else begin
              sec_d = sec_q + SEC_W'(1);
            end
          end
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      sec_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      sec_q   <= sec_d;
    end
  end

  // datapath: request latch, multiplier and accumulator
  always_ff @(posedge clk_i) begin
    if (filter_req) begin
      ch_q   <= channel_i;
      x_q    <= sample_in_i;
      clip_q <= 1'b0;
    end else if (state_q == ST_RUN && advance) begin
      x_q    <= y_sat;
      clip_q <= clip_q | sat;
    end
    if (state_q == ST_RUN && uw.mul_en) begin
      prod_q <= PROD_W'(coef_q[cidx]) * PROD_W'(opnd);
    end
    if (state_q == ST_RUN) begin
      unique case (uw.acc)
        ACC_LOAD: acc_q <= prod_ext;
        ACC_ADD:  acc_q <= acc_q + prod_ext;
        ACC_SUB:  acc_q <= acc_q - prod_ext;
        default:  acc_q <= acc_q;
      endcase
    end
  end

  // coefficient table, pass-through after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCOEF; i++) begin
        coef_q[i] <= (i % 5 == 0) ? SAMPLE_BITS'(1 << COEF_FRAC) : '0;
      end
    end else if (accept && op_e'(operation_i) == OP_WRITE
                 && int'(coefficient_index_i) < NCOEF) begin
      coef_q[coefficient_index_i[CIDX_W-1:0]] <= coefficient_value_i;
    end
  end

  // per-channel, per-section history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NROW; r++) begin
        hx1_q[r] <= '0;
        hx2_q[r] <= '0;
        hy1_q[r] <= '0;
        hy2_q[r] <= '0;
      end
    end else if (accept && op_e'(operation_i) == OP_CLEAR) begin
      for (int r = 0; r < NROW; r++) begin
        hx1_q[r] <= '0;
        hx2_q[r] <= '0;
        hy1_q[r] <= '0;
        hy2_q[r] <= '0;
      end
    end else if (state_q == ST_RUN && advance) begin
      hx1_q[row] <= x_q;
      hx2_q[row] <= hx1_q[row];
      hy1_q[row] <= y_sat;
      hy2_q[row] <= hy1_q[row];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_RUN && advance && last_sec) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RUN && advance && last_sec) begin
      out_sample_q <= y_sat;
      out_ch_q     <= ch_q;
      out_clip_q   <= clip_q | sat;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sample_out_o  = out_sample_q;
  assign channel_out_o = out_ch_q;
  assign clipped_o     = out_clip_q;

  // checks
  a_idle_counters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> step_q == '0 && sec_q == '0)
    else $error("sequencer counters not cleared while idle");

  a_sec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> int'(sec_q) < SECTIONS)
    else $error("section counter out of range");

  a_start_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filter_req |=> state_q == ST_RUN && step_q == '0)
    else $error("filter request did not start the sequencer");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RUN && uw.finish && last_sec))
    else $error("result raised outside the last section finish step");

endmodule

/* bench/tb_biquad_cascade_filter_unit.sv */
// ----------------------------------------------------------------------------
// tb_biquad_cascade_filter_unit
// Self-checking bench for the biquad cascade. A clocked driver sends filter,
// coefficient-write, clear and ignored-opcode requests from a queue and updates a local
// fixed-point cascade model on each accepted request. A clocked monitor
// compares every filtered sample with the oldest predicted one. Both sides
// idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_biquad_cascade_filter_unit;
  import bqc_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;

  // coefficient positions within a section
  localparam int POS_B0 = 0;
  localparam int POS_B1 = 1;
  localparam int POS_B2 = 2;
  localparam int POS_A1 = 3;
  localparam int POS_A2 = 4;

  // opcode the block ignores
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // first index past the coefficient table
  localparam logic [3:0] IDX_NONE = 4'(NCOEF);

  localparam longint SMP_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SMP_MIN = -SMP_MAX - 1;
  localparam smp_t COEF_ONE  = smp_t'(longint'(1) << COEF_FRAC);
  localparam smp_t COEF_HALF = smp_t'(longint'(1) << (COEF_FRAC - 1));

  localparam int RANDOM_REQS    = 600;
  localparam int LONG_HOLD      = 300;
  localparam int HOLD_AFTER     = 40;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct {
    logic [1:0] op;
    logic       ch;
    smp_t       sample;
    logic [3:0] cidx;
    smp_t       cval;
    bit         drain;
  } audio_req_t;

  typedef struct {
    smp_t sample;
    logic ch;
    logic clipped;
  } filtered_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic       in_valid_i          = 1'b0;
  logic       in_ready_o;
  logic [1:0] operation_i         = OP_FILTER;
  logic       channel_i           = 1'b0;
  smp_t       sample_in_i         = '0;
  logic [3:0] coefficient_index_i = '0;
  smp_t       coefficient_value_i = '0;
  logic       out_valid_o;
  logic       out_ready_i         = 1'b0;
  smp_t       sample_out_o;
  logic       channel_out_o;
  logic       clipped_o;

  biquad_cascade_filter_unit u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .operation_i         (operation_i),
    .channel_i           (channel_i),
    .sample_in_i         (sample_in_i),
    .coefficient_index_i (coefficient_index_i),
    .coefficient_value_i (coefficient_value_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .sample_out_o        (sample_out_o),
    .channel_out_o       (channel_out_o),
    .clipped_o           (clipped_o)
  );

  always #2 clk_i = ~clk_i;

  // cascade model state
  smp_t coef_tbl [NCOEF];
  smp_t hist_x1 [CHANNELS][SECTIONS];
  smp_t hist_x2 [CHANNELS][SECTIONS];
  smp_t hist_y1 [CHANNELS][SECTIONS];
  smp_t hist_y2 [CHANNELS][SECTIONS];

  audio_req_t request_q [$];
  filtered_t  filtered_q [$];
  int         fail_count = 0;
  int         reqs_built = 0;
  bit         drain_next = 1'b0;

  // history wipe, shared by reset and clear requests
  function automatic void clear_history();
    for (int c = 0; c < CHANNELS; c++) begin
      for (int s = 0; s < SECTIONS; s++) begin
        hist_x1[c][s] = '0;
        hist_x2[c][s] = '0;
        hist_y1[c][s] = '0;
        hist_y2[c][s] = '0;
      end
    end
  endfunction

  // pass-through coefficients and empty history
  function automatic void reset_cascade();
    for (int i = 0; i < NCOEF; i++) begin
      coef_tbl[i] = (i % 5 == POS_B0) ? COEF_ONE : '0;
    end
    clear_history();
  endfunction

  // run one sample through every section and queue the expected output
  function automatic void filter_sample(logic ch, smp_t sin);
    longint xin;
    longint acc;
    bit     clip;
    int     base;
    xin  = longint'(sin);
    clip = 1'b0;
    for (int s = 0; s < SECTIONS; s++) begin
      base = s * 5;
      acc = longint'(coef_tbl[base + POS_B0]) * xin
          + longint'(coef_tbl[base + POS_B1]) * longint'(hist_x1[ch][s])
          + longint'(coef_tbl[base + POS_B2]) * longint'(hist_x2[ch][s])
          - longint'(coef_tbl[base + POS_A1]) * longint'(hist_y1[ch][s])
          - longint'(coef_tbl[base + POS_A2]) * longint'(hist_y2[ch][s]);
      // round half up, then back to sample scale
      acc = (acc + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
      if (acc > SMP_MAX) begin
        acc  = SMP_MAX;
        clip = 1'b1;
      end
      if (acc < SMP_MIN) begin
        acc  = SMP_MIN;
        clip = 1'b1;
      end
      hist_x2[ch][s] = hist_x1[ch][s];
      hist_x1[ch][s] = smp_t'(xin);
      hist_y2[ch][s] = hist_y1[ch][s];
      hist_y1[ch][s] = smp_t'(acc);
      xin = acc;
    end
    filtered_q.push_back('{sample: smp_t'(xin), ch: ch, clipped: clip});
  endfunction

  // model update for one accepted request
  function automatic void apply_request(audio_req_t r);
    if (r.op == OP_WRITE) begin
      if (r.cidx < NCOEF) coef_tbl[r.cidx] = r.cval;
    end else if (r.op == OP_CLEAR) begin
      clear_history();
    end else if (r.op == OP_FILTER) begin
      if (r.ch < CHANNELS) filter_sample(r.ch, r.sample);
    end
  endfunction

  function automatic void push_req(logic [1:0] op, logic ch, smp_t sample,
                                   logic [3:0] cidx, smp_t cval);
    request_q.push_back('{op: op, ch: ch, sample: sample, cidx: cidx, cval: cval,
                          drain: drain_next});
    drain_next = 1'b0;
    if (op != OP_UNUSED && !(op == OP_WRITE && cidx >= NCOEF)) reqs_built++;
  endfunction

  function automatic void push_filter(logic ch, smp_t sample);
    push_req(OP_FILTER, ch, sample, 4'($urandom), smp_t'($urandom));
  endfunction

  function automatic void push_write(logic [3:0] cidx, smp_t cval);
    push_req(OP_WRITE, 1'($urandom), smp_t'($urandom), cidx, cval);
  endfunction

  // small coefficient in [-0.5, 0.5]
  function automatic smp_t mild_coef();
    return smp_t'($urandom_range(0, 2 * int'(COEF_HALF))) - COEF_HALF;
  endfunction

  function automatic smp_t pick_coef();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return mild_coef();
    if (r < 75) return smp_t'($urandom);
    if (r < 90) return COEF_ONE;
    return '0;
  endfunction

  function automatic smp_t pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return smp_t'($urandom);
    if (r < 85) return smp_t'($urandom_range(0, 2047)) - smp_t'(1024);
    case ($urandom_range(0, 3))
      0:       return smp_t'(SMP_MAX);
      1:       return smp_t'(SMP_MIN);
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // sender gap after an accepted request
  function automatic int sender_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void build_stimulus();
    int nwr;
    int nfil;
    // pass-through at reset, extremes on both channels
    push_filter(1'b0, '0);
    push_filter(1'b0, smp_t'(SMP_MAX));
    push_filter(1'b1, smp_t'(SMP_MIN));
    push_filter(1'b1, '1);
    // ignored opcode and out-of-range coefficient index
    push_req(OP_UNUSED, 1'b1, smp_t'(SMP_MAX), 4'hf, smp_t'(SMP_MIN));
    push_write(IDX_NONE, smp_t'(SMP_MAX));
    // large gain in the first section forces saturation both ways
    push_write(4'(POS_B0), smp_t'(SMP_MAX));
    push_filter(1'b0, smp_t'(SMP_MAX));
    push_filter(1'b1, smp_t'(SMP_MIN));
    // feedback and feedforward taps: three at an extreme, one at one half
    push_write(4'(2 * 5 + POS_A2), smp_t'(SMP_MIN));
    push_write(4'(1 * 5 + POS_A1), COEF_HALF);
    push_write(4'(POS_B1), smp_t'(SMP_MIN));
    push_write(4'(POS_B2), smp_t'(SMP_MAX));
    push_filter(1'b0, smp_t'(24'h400000));
    push_filter(1'b0, smp_t'(24'hc00000));
    // clear once all results are in
    drain_next = 1'b1;
    push_req(OP_CLEAR, 1'b0, '0, '0, '0);
    push_filter(1'b0, smp_t'(1));
    // half gain: rounding of exact halves
    push_write(4'(POS_B0), COEF_HALF);
    push_write(4'(POS_B1), '0);
    push_write(4'(POS_B2), '0);
    push_write(4'(2 * 5 + POS_A2), '0);
    push_write(4'(1 * 5 + POS_A1), '0);
    push_filter(1'b1, smp_t'(1));
    push_filter(1'b1, '1);
    push_filter(1'b1, smp_t'(3));

    reqs_built = 0;
    // random phases: coefficient updates, occasional clears and ignored opcodes, then a burst of samples
    while (reqs_built < RANDOM_REQS) begin
      if ($urandom_range(0, 7) == 0) drain_next = 1'b1;
      if ($urandom_range(0, 4) == 0) begin
        for (int i = 0; i < NCOEF; i++) begin
          push_write(4'(i), (i % 5 == POS_B0) ? COEF_ONE + mild_coef() : mild_coef());
        end
      end else begin
        nwr = $urandom_range(0, 5);
        for (int i = 0; i < nwr; i++) push_write(4'($urandom_range(0, 15)), pick_coef());
      end
      if ($urandom_range(0, 5) == 0) push_req(OP_CLEAR, 1'($urandom), smp_t'($urandom),
                                              4'($urandom), smp_t'($urandom));
      if ($urandom_range(0, 7) == 0) push_req(OP_UNUSED, 1'($urandom), smp_t'($urandom),
                                              4'($urandom), smp_t'($urandom));
      nfil = $urandom_range(8, 40);
      for (int i = 0; i < nfil; i++) push_filter(1'($urandom), pick_sample());
    end
  endfunction

  // request driver
  audio_req_t cur_req;
  int         tx_gap = 0;
  int         tx_cyc = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      tx_cyc++;
      if (in_valid_i && in_ready_o) begin
        apply_request(cur_req);
        tx_gap = sender_gap((tx_cyc % 512) < 128);
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (request_q.size() != 0 &&
                     !(request_q[0].drain && filtered_q.size() != 0)) begin
          cur_req = request_q.pop_front();
          operation_i         <= cur_req.op;
          channel_i           <= cur_req.ch;
          sample_in_i         <= cur_req.sample;
          coefficient_index_i <= cur_req.cidx;
          coefficient_value_i <= cur_req.cval;
          in_valid_i          <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver back-pressure
  filtered_t exp_res;
  int        rx_stall    = 0;
  int        rx_cyc      = 0;
  int        results_got = 0;
  bit        hold_done   = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      rx_cyc++;
      if (out_valid_o && out_ready_i) begin
        results_got++;
        if (filtered_q.size() == 0) begin
          $error("unexpected result: sample_out=%0d channel_out=%0d clipped=%0d",
                 sample_out_o, channel_out_o, clipped_o);
          fail_count++;
        end else begin
          exp_res = filtered_q.pop_front();
          if (sample_out_o !== exp_res.sample) begin
            $error("sample_out: expected %0d, actual %0d", exp_res.sample, sample_out_o);
            fail_count++;
          end
          if (channel_out_o !== exp_res.ch) begin
            $error("channel_out: expected %0d, actual %0d", exp_res.ch, channel_out_o);
            fail_count++;
          end
          if (clipped_o !== exp_res.clipped) begin
            $error("clipped: expected %0d, actual %0d", exp_res.clipped, clipped_o);
            fail_count++;
          end
        end
      end
      // one long hold-off so the block backs up into its input
      if (!hold_done && results_got >= HOLD_AFTER) begin
        hold_done = 1'b1;
        rx_stall  = LONG_HOLD;
      end else if (rx_stall == 0 && (rx_cyc % 640) >= 160 && $urandom_range(0, 15) == 0) begin
        rx_stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(20, 80);
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // reset, stimulus build and end of run
  initial begin
    reset_cascade();
    build_stimulus();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (request_q.size() != 0 || in_valid_i || filtered_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/bqc_pkg.sv
rtl/biquad_cascade_filter_unit.sv
bench/tb_biquad_cascade_filter_unit.sv
